// File: rtl/core/rhpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhpc_pkg
// Shared constants, codes and types for the rolling hash pattern censor.
// ----------------------------------------------------------------------------
package rhpc_pkg;

    localparam int STACK_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    localparam int HASH_W    = 30;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 16;
    localparam int PLEN_W    = 17;
    localparam int COUNT_W   = 17;
    localparam int BASE_BITS = 5;
    localparam int MCNT_W    = 5;

    localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000009;
    localparam logic [BASE_BITS-1:0] HASH_BASE = 5'd31;

    // residue arithmetic runs two bits wider than the prime
    localparam logic [HASH_W+1:0] PRIME_X1 = 32'd1000000009;
    localparam logic [HASH_W+1:0] PRIME_X2 = 32'd2000000018;

    // opcodes carried on s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic REG_PATTERN_HASH   = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_RD_WAIT   = 8'b0000_0010,
        ST_POW_MUL   = 8'b0000_0100,
        ST_HASH_MUL  = 8'b0000_1000,
        ST_BASE_RD   = 8'b0001_0000,
        ST_BASE_WAIT = 8'b0010_0000,
        ST_CMP_MUL   = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    // one stack entry: the byte, the prefix hash and 31^position
    typedef struct packed {
        logic [HASH_W-1:0] power;
        logic [HASH_W-1:0] hash;
        logic [BYTE_W-1:0] text;
    } entry_t;

endpackage

// File: rtl/core/rolling_hash_pattern_censor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_pattern_censor
// Byte stack with polynomial prefix hashes mod 1e9+9; pops the pattern window
// whenever the top of the stack hashes equal to the pattern.
// A read does a registered memory read unless past the depth; a push runs the
// power and hash multiplies, then a window check if the depth reaches the length.
// Throughput: one item at a time, the next taken once the result is staged.
// The bit-serial modular multiplier (5, 8 and 30 steps) sets the push time.
// Reset: synchronous; clears depth and pattern hash, sets length to one; stack
// memory is not cleared, only entries below the depth are ever read.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_censor (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [29:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // text_byte[7:0], read_index[23:8]
    input  logic [0:0]  s_tuser,   // opcode[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // kept_count[16:0], window_removed[17],
                                   // overflow[18], read_byte[26:19], zero
);
    import rhpc_pkg::*;

    state_t              state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [HASH_W-1:0]   top_hash_reg, top_hash_next;
    logic [HASH_W-1:0]   top_pow_reg, top_pow_next;
    logic [HASH_W-1:0]   ph_reg, ph_next;
    logic [PLEN_W-1:0]   plen_reg, plen_next;
    logic [HASH_W-1:0]   mul_a_reg, mul_a_next;
    logic [HASH_W-1:0]   mul_b_reg, mul_b_next;
    logic [HASH_W-1:0]   mul_acc_reg, mul_acc_next;
    logic [MCNT_W-1:0]   mul_cnt_reg, mul_cnt_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [DEPTH_W-1:0]  base_reg, base_next;
    logic [HASH_W-1:0]   hb_reg, hb_next;
    logic [HASH_W-1:0]   pb_reg, pb_next;
    logic                removed_reg, removed_next;
    logic                over_reg, over_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;

    entry_t              mem [STACK_DEPTH];
    entry_t              rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wr_addr;
    entry_t              mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;

    logic                in_fire;
    logic [INDEX_W-1:0]  in_index;
    logic [HASH_W+1:0]   step_sum;
    logic [HASH_W-1:0]   step_res;
    logic [HASH_W:0]     hsum;
    logic [HASH_W-1:0]   h_new;
    logic [HASH_W:0]     wdiff;
    logic [HASH_W-1:0]   win;
    logic [HASH_W-1:0]   ph_red;
    logic [PLEN_W-1:0]   plen_eff;
    logic [DEPTH_W-1:0]  d_new;
    logic [DEPTH_W-1:0]  base_m1;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_index = s_tdata[23:8];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared multiplier step: acc = 2*acc + bit*a, reduced mod P
    always_comb begin
        step_sum = {1'b0, mul_acc_reg, 1'b0} +
                   (mul_b_reg[HASH_W-1] ? {2'b00, mul_a_reg} : '0);
        if (step_sum >= PRIME_X2) begin
            step_res = HASH_W'(step_sum - PRIME_X2);
        end else if (step_sum >= PRIME_X1) begin
            step_res = HASH_W'(step_sum - PRIME_X1);
        end else begin
            step_res = HASH_W'(step_sum);
        end
    end

    always_comb begin
        hsum  = {1'b0, top_hash_reg} + {1'b0, mul_acc_reg};
        h_new = (hsum >= {1'b0, HASH_PRIME}) ? HASH_W'(hsum - {1'b0, HASH_PRIME})
                                             : HASH_W'(hsum);
        wdiff = {1'b0, top_hash_reg} + {1'b0, HASH_PRIME} - {1'b0, hb_reg};
        win   = (wdiff >= {1'b0, HASH_PRIME}) ? HASH_W'(wdiff - {1'b0, HASH_PRIME})
                                              : HASH_W'(wdiff);
        ph_red   = (ph_reg >= HASH_PRIME) ? (ph_reg - HASH_PRIME) : ph_reg;
        plen_eff = (plen_reg == '0) ? PLEN_W'(1) : plen_reg;
        d_new    = depth_reg + DEPTH_W'(1);
        base_m1  = base_reg - DEPTH_W'(1);
    end

    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        top_hash_next = top_hash_reg;
        top_pow_next  = top_pow_reg;
        ph_next       = ph_reg;
        plen_next     = plen_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        mul_acc_next  = mul_acc_reg;
        mul_cnt_next  = mul_cnt_reg;
        byte_next     = byte_reg;
        base_next     = base_reg;
        hb_next       = hb_reg;
        pb_next       = pb_reg;
        removed_next  = removed_reg;
        over_next     = over_reg;
        rbyte_next    = rbyte_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_wr_addr   = ADDR_W'(depth_reg);
        mem_wr_data   = '{power: top_pow_reg, hash: h_new, text: byte_reg};
        mem_rd_en     = 1'b0;
        mem_rd_addr   = ADDR_W'(base_m1);

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PATTERN_HASH:   ph_next   = cfg_wdata[HASH_W-1:0];
                REG_PATTERN_LENGTH: plen_next = cfg_wdata[PLEN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    byte_next    = s_tdata[7:0];
                    removed_next = 1'b0;
                    over_next    = 1'b0;
                    rbyte_next   = '0;
                    if (s_tuser[0] == OP_READ) begin
                        if (32'(in_index) < 32'(depth_reg)) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = ADDR_W'(in_index);
                            state_next  = ST_RD_WAIT;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (32'(depth_reg) >= STACK_DEPTH) begin
                        over_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        mul_a_next   = top_pow_reg;
                        mul_b_next   = HASH_W'(HASH_BASE) << (HASH_W - BASE_BITS);
                        mul_acc_next = '0;
                        mul_cnt_next = MCNT_W'(BASE_BITS);
                        state_next   = ST_POW_MUL;
                    end
                end
            end
            ST_RD_WAIT: begin
                rbyte_next = rd_data_reg.text;
                state_next = ST_DONE;
            end
            ST_POW_MUL: begin
                if (mul_cnt_reg == '0) begin
                    // 31^d for the new entry
                    top_pow_next = mul_acc_reg;
                    mul_a_next   = mul_acc_reg;
                    mul_b_next   = HASH_W'(byte_reg) << (HASH_W - BYTE_W);
                    mul_acc_next = '0;
                    mul_cnt_next = MCNT_W'(BYTE_W);
                    state_next   = ST_HASH_MUL;
                end else begin
                    mul_acc_next = step_res;
                    mul_b_next   = mul_b_reg << 1;
                    mul_cnt_next = mul_cnt_reg - MCNT_W'(1);
                end
            end
            ST_HASH_MUL: begin
                if (mul_cnt_reg == '0) begin
                    mem_we        = 1'b1;
                    depth_next    = d_new;
                    top_hash_next = h_new;
                    if (32'(d_new) >= 32'(plen_eff)) begin
                        base_next  = DEPTH_W'(32'(d_new) - 32'(plen_eff));
                        state_next = ST_BASE_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    mul_acc_next = step_res;
                    mul_b_next   = mul_b_reg << 1;
                    mul_cnt_next = mul_cnt_reg - MCNT_W'(1);
                end
            end
            ST_BASE_RD: begin
                if (base_reg == '0) begin
                    // empty prefix: hash 0, power 1
                    hb_next      = '0;
                    pb_next      = HASH_W'(1);
                    mul_a_next   = ph_red;
                    mul_b_next   = HASH_W'(1);
                    mul_acc_next = '0;
                    mul_cnt_next = MCNT_W'(HASH_W);
                    state_next   = ST_CMP_MUL;
                end else begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_BASE_WAIT;
                end
            end
            ST_BASE_WAIT: begin
                hb_next      = rd_data_reg.hash;
                pb_next      = rd_data_reg.power;
                mul_a_next   = ph_red;
                mul_b_next   = rd_data_reg.power;
                mul_acc_next = '0;
                mul_cnt_next = MCNT_W'(HASH_W);
                state_next   = ST_CMP_MUL;
            end
            ST_CMP_MUL: begin
                if (mul_cnt_reg == '0) begin
                    if (win == mul_acc_reg) begin
                        // drop the matched window
                        depth_next    = base_reg;
                        top_hash_next = hb_reg;
                        top_pow_next  = pb_reg;
                        removed_next  = 1'b1;
                    end
                    state_next = ST_DONE;
                end else begin
                    mul_acc_next = step_res;
                    mul_b_next   = mul_b_reg << 1;
                    mul_cnt_next = mul_cnt_reg - MCNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, rbyte_reg, over_reg, removed_reg,
                                     COUNT_W'(depth_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            top_hash_reg <= '0;
            top_pow_reg  <= HASH_W'(1);
            ph_reg       <= '0;
            plen_reg     <= PLEN_W'(1);
            mul_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            top_hash_reg <= top_hash_next;
            top_pow_reg  <= top_pow_next;
            ph_reg       <= ph_next;
            plen_reg     <= plen_next;
            mul_cnt_reg  <= mul_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_acc_reg <= mul_acc_next;
        byte_reg    <= byte_next;
        base_reg    <= base_next;
        hb_reg      <= hb_next;
        pb_reg      <= pb_next;
        removed_reg <= removed_next;
        over_reg    <= over_next;
        rbyte_reg   <= rbyte_next;
        m_tdata_reg <= m_tdata_next;
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= STACK_DEPTH)
        else $error("stack depth beyond capacity");

    a_top_hash_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        top_hash_reg < HASH_PRIME)
        else $error("top prefix hash not reduced");

    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_cnt_reg != '0) |-> (state_reg == ST_POW_MUL ||
                                 state_reg == ST_HASH_MUL ||
                                 state_reg == ST_CMP_MUL))
        else $error("multiplier busy outside a multiply state");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser[0] == OP_PUSH && 32'(depth_reg) >= STACK_DEPTH)
        |=> (state_reg == ST_DONE && over_reg && $stable(depth_reg)))
        else $error("push into full stack not dropped");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[17] && m_tdata_reg[18]))
        else $error("removal and overflow flagged together");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams pushes and reads into the pattern censor and checks every result
// against a software copy of the hashed byte stack. Directed cases first,
// then random phases built around the configured pattern.
// ----------------------------------------------------------------------------
module testbench;
    import rhpc_pkg::*;

    localparam longint unsigned MOD  = HASH_PRIME;
    localparam longint unsigned BASE = HASH_BASE;

    typedef logic [7:0] byte_q_t[$];

    // result fields as packed on m_tdata, lowest bit last
    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  read_byte;
        logic        overflow;
        logic        window_removed;
        logic [16:0] kept_count;
    } censor_result_t;

    class censor_scoreboard;
        logic [7:0]      kept_bytes[STACK_DEPTH];
        longint unsigned prefix_sums[STACK_DEPTH + 1];
        longint unsigned radix_powers[STACK_DEPTH + 1];
        int unsigned     depth;
        logic [29:0]     pat_hash;
        logic [16:0]     pat_len;
        censor_result_t  awaited_q[$];
        int              errors;

        function new();
            radix_powers[0] = 1;
            for (int k = 1; k <= STACK_DEPTH; k++)
                radix_powers[k] = (radix_powers[k-1] * BASE) % MOD;
            prefix_sums[0] = 0;
            depth    = 0;
            pat_hash = '0;
            pat_len  = 17'd1;
            errors   = 0;
        endfunction

        function void set_reg(logic addr, logic [29:0] value);
            if (addr == REG_PATTERN_HASH)
                pat_hash = value;
            else
                pat_len = value[16:0];
        endfunction

        function void note_input(logic op, logic [7:0] b, logic [15:0] idx);
            censor_result_t  r;
            int unsigned     len, d, base_pos;
            longint unsigned h, win, want;
            r = '0;
            if (op == OP_READ) begin
                if (idx < depth)
                    r.read_byte = kept_bytes[idx];
            end else if (depth >= STACK_DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                len = (pat_len == 0) ? 1 : pat_len;
                d   = depth + 1;
                h   = (prefix_sums[d-1] + (radix_powers[d] * b) % MOD) % MOD;
                kept_bytes[d-1] = b;
                prefix_sums[d]  = h;
                depth = d;
                if (d >= len) begin
                    base_pos = d - len;
                    win  = (h + MOD - prefix_sums[base_pos]) % MOD;
                    want = (longint'(pat_hash) * radix_powers[base_pos]) % MOD;
                    if (win == want) begin
                        depth = base_pos;
                        r.window_removed = 1'b1;
                    end
                end
            end
            r.kept_count = depth[16:0];
            awaited_q = {awaited_q, r};
        endfunction

        function void check_result(logic [31:0] data);
            censor_result_t got, exp;
            got = data;
            if (awaited_q.size() == 0) begin
                $error("unexpected result transfer: data %h", data);
                errors++;
                return;
            end
            exp = awaited_q.pop_front();
            if (got.kept_count != exp.kept_count) begin
                $error("kept_count: expected %0d, got %0d", exp.kept_count, got.kept_count);
                errors++;
            end
            if (got.window_removed != exp.window_removed) begin
                $error("window_removed: expected %0d, got %0d",
                       exp.window_removed, got.window_removed);
                errors++;
            end
            if (got.overflow != exp.overflow) begin
                $error("overflow: expected %0d, got %0d", exp.overflow, got.overflow);
                errors++;
            end
            if (got.read_byte != exp.read_byte) begin
                $error("read_byte: expected %0d, got %0d", exp.read_byte, got.read_byte);
                errors++;
            end
            if (got.pad != exp.pad) begin
                $error("pad: expected %0d, got %0d", exp.pad, got.pad);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [29:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // text_byte[7:0], read_index[23:8]
    logic [0:0]  s_tuser;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // kept_count[16:0], window_removed[17], overflow[18],
                            // read_byte[26:19], zero

    censor_scoreboard sb = new();
    bit               quiet = 1'b0;
    byte_q_t          pattern_q;

    rolling_hash_pattern_censor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [29:0] hash_of(input byte_q_t q);
        longint unsigned acc, pw;
        acc = 0;
        pw  = 1;
        foreach (q[i]) begin
            pw  = (pw * BASE) % MOD;
            acc = (acc + q[i] * pw) % MOD;
        end
        return acc[29:0];
    endfunction

    // offer one item, optionally after an idle burst, and hold until transfer
    task automatic offer_item(input logic op, input logic [7:0] b, input logic [15:0] idx);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, b};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, b, idx);
    endtask

    task automatic push_byte(input logic [7:0] b);
        offer_item(OP_PUSH, b, 16'($urandom_range(0, 65535)));
    endtask

    task automatic read_at(input logic [15:0] idx);
        offer_item(OP_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic push_text(input byte_q_t q);
        foreach (q[i]) push_byte(q[i]);
    endtask

    // drop valid and hold until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [29:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(addr, value);
        @(posedge aclk);
    endtask

    task automatic set_pattern(input logic [29:0] h, input logic [16:0] len);
        wait_idle();
        write_reg(REG_PATTERN_HASH, h);
        write_reg(REG_PATTERN_LENGTH, 30'(len));
    endtask

    task automatic run_phase(input int n_items);
        int          len, alpha_n, alpha_base, pos, act, done_cnt;
        logic [29:0] h;
        byte_q_t     text, tmp;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        alpha_n    = $urandom_range(2, 4);
        alpha_base = $urandom_range(0, 256 - alpha_n);
        pattern_q  = {};
        repeat (len)
            pattern_q = {pattern_q, 8'(alpha_base + $urandom_range(0, alpha_n - 1))};
        h = hash_of(pattern_q);
        case ($urandom_range(0, 9))
            0: h = 30'($urandom_range(0, 30'h3FFF_FFFF));
            1: if (longint'(h) + MOD < (64'd1 << 30)) h = 30'(longint'(h) + MOD);
            default: ;
        endcase
        set_pattern(h, 17'(len));
        done_cnt = 0;
        while (done_cnt < n_items) begin
            act  = $urandom_range(0, 99);
            text = {};
            if (act < 50) begin
                // pattern with copies nested inside it
                text = pattern_q;
                repeat ($urandom_range(0, 2)) begin
                    pos = $urandom_range(0, text.size());
                    tmp = {};
                    for (int i = 0; i < pos; i++) tmp = {tmp, text[i]};
                    foreach (pattern_q[i]) tmp = {tmp, pattern_q[i]};
                    for (int i = pos; i < text.size(); i++) tmp = {tmp, text[i]};
                    text = tmp;
                end
            end else if (act < 65 && len > 1) begin
                // broken: a prefix only
                for (int i = 0; i < $urandom_range(1, len - 1); i++)
                    text = {text, pattern_q[i]};
            end else if (act < 80) begin
                repeat ($urandom_range(1, 3))
                    text = {text, 8'(alpha_base + $urandom_range(0, alpha_n - 1))};
            end else if (act < 85) begin
                text = {text, 8'($urandom_range(0, 255))};
            end else if (act < 99) begin
                if ($urandom_range(0, 3) == 0 || sb.depth == 0)
                    read_at(16'($urandom_range(0, 65535)));
                else
                    read_at(16'($urandom_range(0, sb.depth - 1)));
                done_cnt++;
            end else begin
                wait_idle();
            end
            push_text(text);
            done_cnt += text.size();
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 40)) begin
                @(posedge aclk);
                m_tready <= 1'b1;
            end
            if (!quiet) begin
                repeat ($urandom_range(1, 12)) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial begin
        byte_q_t q;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_PATTERN_HASH;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_PUSH;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pattern: hash zero, length one, so a zero byte matches
        push_byte(8'h00);
        push_byte(8'hFF);
        read_at(16'd0);
        read_at(16'hFFFF);

        // zero length acts as one
        q = {8'h41};
        set_pattern(hash_of(q), 17'd0);
        push_byte(8'h41);
        push_byte(8'h42);

        // hash above the prime is reduced
        q = {8'h43};
        set_pattern(30'(longint'(hash_of(q)) + MOD), 17'd1);
        push_byte(8'h43);
        push_byte(8'h44);

        // removal exposes a second match
        q = {8'h61, 8'h62, 8'h63};
        set_pattern(hash_of(q), 17'd3);
        push_text({8'h61, 8'h62, 8'h61, 8'h62, 8'h63, 8'h63});
        read_at(16'd0);
        read_at(16'd1);

        // pattern longer than the stack never matches
        set_pattern(30'h3FFF_FFFF, 17'h1FFFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        read_at(16'd2);

        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                quiet = 1'b1;
            run_phase(205);
        end

        wait_idle();
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #300_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rhpc_pkg.sv
rtl/core/rolling_hash_pattern_censor.sv
test/testbench.sv
